// ----- hdl/les_pkg.sv -----
// shared types, constants and register indexes for the led effect sequencer
package les_pkg;

	localparam int LedW       = 8;
	localparam int ModeW      = 3;
	localparam int StepW      = 8;
	localparam int LenW       = StepW + 1;
	localparam int BandW      = 3;
	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = 8;
	localparam int InDataW    = 8;
	localparam int OutDataW   = 16;

	localparam logic [StepW-1:0] StepPeriodReset = 8'd3;
	localparam logic [BandW-1:0] BandWidthReset  = 3'd3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_STEP_PERIOD = 2'd0,
		REG_BAND_WIDTH  = 2'd1
	} cfg_reg_t;

	typedef enum logic [ModeW-1:0] {
		MODE_UP_COUNT   = 3'd0,
		MODE_DOWN_COUNT = 3'd1,
		MODE_WALK_RIGHT = 3'd2,
		MODE_WALK_LEFT  = 3'd3,
		MODE_FILL       = 3'd4,
		MODE_BLINK      = 3'd5,
		MODE_BOUNCE     = 3'd6,
		MODE_MIRROR     = 3'd7
	} mode_t;

	// request to the pattern lookup
	typedef struct packed {
		mode_t            mode;
		logic [StepW-1:0] step;
		logic [BandW-1:0] band;
	} pat_req_t;

	// answer from the pattern lookup
	typedef struct packed {
		logic [LedW-1:0] leds;
		logic [LenW-1:0] len;
	} pat_rsp_t;

	// one result item
	typedef struct packed {
		mode_t           mode;
		logic [LedW-1:0] leds;
	} result_t;

endpackage

// ----- hdl/les_pattern.sv -----
// pattern lookup: led value and step count of each effect
module les_pattern
	import les_pkg::*;
(
	input  pat_req_t req,
	input  logic     step_ok,
	output pat_rsp_t rsp
);

	localparam logic [LedW-1:0] Mirror [8] = '{
		8'h81, 8'hC3, 8'hE7, 8'hFF, 8'h7E, 8'h3C, 8'h18, 8'h00
	};

	logic [BandW-1:0] band_w;
	logic [3:0]       dif;
	logic [3:0]       s4;
	logic [3:0]       sh;
	logic [LedW-1:0]  band_mask;
	logic [2:0]       s3;

	always_comb begin
		band_w    = (req.band == '0) ? 3'd1 : req.band;
		dif       = 4'd8 - {1'b0, band_w};
		s4        = req.step[3:0];
		s3        = req.step[2:0];
		// rising leg shifts by step plus one, falling leg comes back to zero
		sh        = (s4 < dif) ? (s4 + 4'd1) : ({dif[2:0], 1'b0} - s4 - 4'd1);
		band_mask = LedW'((9'd1 << band_w) - 9'd1);
	end

	always_comb begin
		rsp.len  = LenW'(8);
		rsp.leds = '0;
		case (req.mode)
			MODE_UP_COUNT: begin
				rsp.len  = LenW'(255);
				rsp.leds = req.step;
			end
			MODE_DOWN_COUNT: begin
				rsp.len  = LenW'(256);
				rsp.leds = ~req.step;
			end
			MODE_WALK_RIGHT: begin
				rsp.leds = LedW'(1) << s3;
			end
			MODE_WALK_LEFT: begin
				rsp.leds = LedW'(1) << (3'd7 - s3);
			end
			MODE_FILL: begin
				rsp.len = LenW'(16);
				if (!s4[3]) begin
					rsp.leds = LedW'((9'd2 << s3) - 9'd1);
				end else begin
					rsp.leds = LedW'((9'd1 << (3'd7 - s3)) - 9'd1);
				end
			end
			MODE_BLINK: begin
				rsp.len  = LenW'(2);
				rsp.leds = (req.step != '0) ? 8'hFF : 8'h00;
			end
			MODE_BOUNCE: begin
				rsp.len  = LenW'({dif, 1'b0});
				rsp.leds = band_mask << sh[2:0];
			end
			MODE_MIRROR: begin
				rsp.leds = Mirror[s3];
			end
			default: begin
				rsp.leds = '0;
			end
		endcase
		// value only meaningful once the step is inside the pattern
		if (!step_ok) begin
			rsp.leds = rsp.leds;
		end
	end

endmodule

// ----- hdl/les_out_reg.sv -----
// output register between the sequencer logic and the result stream
module les_out_reg
	import les_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  result_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    valid_q;
	result_t data_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_data;
		end
	end

endmodule

// ----- hdl/led_effect_sequencer_top.sv -----
// LED effect sequencer: one tick per input transfer, takes a new tick every cycle when the
// result side keeps up; each result appears in the cycle after its tick through a single output
// register, so the rate is one item per cycle set by that register. Button bits are active
// low and a press toggles a mode bit; mode {switch, button two, button one} picks one of
// eight 8-led effects, each step held for step_period ticks. Registers: index 0 step_period,
// index 1 band_width; write them only while no tick is in flight.
module led_effect_sequencer_top
	import les_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // [0] button_one_level, [1] button_two_level,
	                                       // [2] switch_level, [7:3] zero
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,   // [7:0] led_pattern, [10:8] active_mode, [15:11] zero
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	logic [StepW-1:0] step_period_q;
	logic [BandW-1:0] band_width_q;
	logic [1:0]       prev_btn_q;
	logic [ModeW-1:0] mode_q;
	logic [StepW-1:0] step_q;
	logic [StepW-1:0] tick_q;

	logic             accept;
	logic [1:0]       btn_now;
	logic [1:0]       pressed;
	logic [ModeW-1:0] mode_d;
	logic             changed;
	logic [StepW-1:0] step_base;
	logic [StepW-1:0] tick_base;
	logic [StepW-1:0] step_cur;
	logic [StepW-1:0] tick_inc;
	logic [StepW-1:0] period;
	logic [LenW-1:0]  step_next;
	logic [StepW-1:0] step_d;
	logic [StepW-1:0] tick_d;
	logic             step_ok;
	pat_req_t         len_req;
	pat_rsp_t         len_rsp;
	pat_req_t         val_req;
	pat_rsp_t         val_rsp;
	result_t          result;
	result_t          out_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_period_q <= StepPeriodReset;
			band_width_q  <= BandWidthReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_STEP_PERIOD: step_period_q <= cfg_data;
				REG_BAND_WIDTH:  band_width_q  <= cfg_data[BandW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		btn_now   = s_tdata[1:0];
		pressed   = prev_btn_q & ~btn_now;
		mode_d    = {s_tdata[2], mode_q[1:0] ^ pressed};
		changed   = (mode_d != mode_q);
		step_base = changed ? '0 : step_q;
		tick_base = changed ? '0 : tick_q;
	end

	// length of the new mode, used to pull a stale step back into range
	assign len_req.mode = mode_t'(mode_d);
	assign len_req.step = step_base;
	assign len_req.band = band_width_q;

	les_pattern u_len (
		.req     (len_req),
		.step_ok (1'b0),
		.rsp     (len_rsp)
	);

	always_comb begin
		step_cur = ({1'b0, step_base} >= len_rsp.len) ? '0 : step_base;
		step_ok  = 1'b1;
		period   = (step_period_q == '0) ? 8'd1 : step_period_q;
		tick_inc = tick_base + 8'd1;
		step_next = {1'b0, step_cur} + LenW'(1);
		if (tick_inc >= period) begin
			tick_d = '0;
			step_d = (step_next >= len_rsp.len) ? '0 : step_next[StepW-1:0];
		end else begin
			tick_d = tick_inc;
			step_d = step_cur;
		end
	end

	assign val_req.mode = mode_t'(mode_d);
	assign val_req.step = step_cur;
	assign val_req.band = band_width_q;

	les_pattern u_val (
		.req     (val_req),
		.step_ok (step_ok),
		.rsp     (val_rsp)
	);

	assign result.mode = mode_t'(mode_d);
	assign result.leds = val_rsp.leds;

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_btn_q <= 2'b11;
			mode_q     <= '0;
			step_q     <= '0;
			tick_q     <= '0;
		end else if (accept) begin
			prev_btn_q <= btn_now;
			mode_q     <= mode_d;
			step_q     <= step_d;
			tick_q     <= tick_d;
		end
	end

	les_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (result),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data)
	);

	assign m_tdata = {5'b0, out_data.mode, out_data.leds};

endmodule
